// ===== rtl/core/lcfg_pkg.sv =====
// Package for the linear color fade generator.
// Holds the sequencer state type, register codes and fixed widths.
// No dependencies.
package lcfg_pkg;

    localparam int TIME_W      = 46;
    localparam int COLOR_W     = 32;
    localparam int FADE_W      = 16;
    localparam int STEP_W      = 32;
    localparam int OUT_W       = 8;
    localparam int CFG_ADDR_W  = 4;
    localparam int CFG_DATA_W  = 32;
    localparam int NUM_CHAN    = 4;
    localparam int CHAN_IDX_W  = 2;

    localparam logic [29:0] NS_PER_SECOND = 30'd1000000000;

    localparam logic [FADE_W-1:0] FADE_RESET = 16'd1;
    localparam logic [STEP_W-1:0] STEP_RESET = 32'd1000000;

    localparam logic [CFG_ADDR_W-1:0] REG_START_COLOR  = 4'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_END_COLOR    = 4'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_FADE_SECONDS = 4'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_STEP_NS      = 4'd3;

    localparam logic [CHAN_IDX_W-1:0] LAST_CHAN = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TOTAL,
        ST_CHECK,
        ST_TIME,
        ST_LOAD,
        ST_MUL,
        ST_DIV,
        ST_WRITE,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/core/lcfg_if.sv =====
// Handshake interfaces of the linear color fade generator.
// Depends on lcfg_pkg for widths.
interface lcfg_tick_if;
    logic valid;
    logic ready;
    logic restart;
    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

interface lcfg_color_if;
    logic                            valid;
    logic                            ready;
    logic [lcfg_pkg::OUT_W-1:0]      red;
    logic [lcfg_pkg::OUT_W-1:0]      green;
    logic [lcfg_pkg::OUT_W-1:0]      blue;
    logic [lcfg_pkg::OUT_W-1:0]      brightness;
    logic                            last;
    logic                            error;
    modport source (output valid, output red, output green, output blue,
                    output brightness, output last, output error, input ready);
    modport sink (input valid, input red, input green, input blue,
                  input brightness, input last, input error, output ready);
endinterface

interface lcfg_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [lcfg_pkg::CFG_ADDR_W-1:0]    addr;
    logic [lcfg_pkg::CFG_DATA_W-1:0]    data;
    modport source (output valid, output addr, output data, input ready);
    modport sink (input valid, input addr, input data, output ready);
endinterface

// ===== rtl/core/linear_color_fade_generator.sv =====
// Linear color fade generator top level: sequencer plus one shared adder
// used for shift-add multiply and restoring divide. Depends on lcfg_pkg, lcfg_if.
//
//  channel | dir | payload                                   | handshake
//  cfg     | in  | addr, data                                | valid/ready
//  tick    | in  | restart                                   | valid/ready
//  color   | out | red, green, blue, brightness, last, error | valid/ready
//
// Per channel, a color item takes CHANNEL_BITS multiply and CHANNEL_BITS divide
// steps on the shared adder, after the TOTAL, CHECK and TIME states. A tick is
// taken only in IDLE, so a new tick waits until the last item has left DONE.
// An invalid setting goes from CHECK straight to DONE.
// Reset: fade_seconds = 1, step_ns = 1000000, colors and elapsed time zero.
// The result sits in an output register; a new tick is taken while it waits,
// and the next result holds in the sequencer until the register is free.
module linear_color_fade_generator #(
    parameter int CHANNEL_BITS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    lcfg_cfg_if.sink            cfg,
    lcfg_tick_if.sink           tick,
    lcfg_color_if.source        color
);

    localparam int TW    = lcfg_pkg::TIME_W;
    localparam int W     = TW + CHANNEL_BITS;
    localparam int CNT_W = (CHANNEL_BITS > 1) ? $clog2(CHANNEL_BITS) : 1;
    localparam int OW    = lcfg_pkg::OUT_W;

    lcfg_pkg::state_t state_reg, state_next;

    logic [lcfg_pkg::COLOR_W-1:0] start_reg, end_reg;
    logic [lcfg_pkg::FADE_W-1:0]  fade_reg;
    logic [lcfg_pkg::STEP_W-1:0]  step_reg;
    logic [TW-1:0]                elapsed_reg, elapsed_next;

    logic                         restart_reg, restart_next;
    logic [TW-1:0]                total_reg, total_next;
    logic [TW-1:0]                t_reg, t_next;
    logic                         err_reg, err_next;
    logic                         last_reg, last_next;
    logic [lcfg_pkg::CHAN_IDX_W-1:0] ch_reg, ch_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic [CHANNEL_BITS-1:0]      mcand_reg, mcand_next;
    logic [W-1:0]                 acc_reg, acc_next;
    logic [OW-1:0]                res_reg [lcfg_pkg::NUM_CHAN];
    logic [OW-1:0]                res_next [lcfg_pkg::NUM_CHAN];

    logic                         out_valid_reg, out_valid_next;
    logic [OW-1:0]                out_red_reg, out_red_next;
    logic [OW-1:0]                out_green_reg, out_green_next;
    logic [OW-1:0]                out_blue_reg, out_blue_next;
    logic [OW-1:0]                out_bright_reg, out_bright_next;
    logic                         out_last_reg, out_last_next;
    logic                         out_err_reg, out_err_next;

    // channel extraction, top channel first
    logic [63:0]             start_ext, end_ext;
    logic [CHANNEL_BITS-1:0] chan_s [lcfg_pkg::NUM_CHAN];
    logic [CHANNEL_BITS-1:0] chan_e [lcfg_pkg::NUM_CHAN];

    assign start_ext = {32'd0, start_reg};
    assign end_ext   = {32'd0, end_reg};

    for (genvar gi = 0; gi < lcfg_pkg::NUM_CHAN; gi++) begin : g_chan
        localparam int SH = (3 - gi) * CHANNEL_BITS;
        assign chan_s[gi] = start_ext[SH +: CHANNEL_BITS];
        assign chan_e[gi] = end_ext[SH +: CHANNEL_BITS];
    end

    logic [CHANNEL_BITS-1:0] cur_s, cur_e, cur_diff, cur_q, cur_val;
    logic                    cur_up;
    logic [CHANNEL_BITS+OW-1:0] val_wide;

    assign cur_s    = chan_s[ch_reg];
    assign cur_e    = chan_e[ch_reg];
    assign cur_up   = cur_s < cur_e;
    assign cur_diff = cur_up ? (cur_e - cur_s) : (cur_s - cur_e);
    assign cur_q    = acc_reg[CHANNEL_BITS-1:0];
    assign cur_val  = cur_up ? (cur_s + cur_q) : (cur_s - cur_q);
    assign val_wide = {{OW{1'b0}}, cur_val};

    // shared adder
    logic [W-1:0] alu_a, alu_b;
    logic         alu_sub;
    logic [W:0]   alu_sum;

    assign alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                     + {{W{1'b0}}, alu_sub};

    logic [TW:0]  rem_shift;
    logic [TW-1:0] rem_new;
    logic         q_bit;
    logic [CHANNEL_BITS-1:0] low_shift;

    assign rem_shift = {acc_reg[W-1:CHANNEL_BITS], acc_reg[CHANNEL_BITS-1]};
    assign q_bit     = (state_reg == lcfg_pkg::ST_DIV) && alu_sum[W];
    assign rem_new   = q_bit ? alu_sum[TW-1:0] : rem_shift[TW-1:0];
    assign low_shift = (acc_reg[CHANNEL_BITS-1:0] << 1) | CHANNEL_BITS'(q_bit);

    always_comb
    begin
        alu_a   = {acc_reg[W-2:0], 1'b0};
        alu_b   = {W{1'b0}};
        alu_sub = 1'b0;
        if (state_reg == lcfg_pkg::ST_DIV)
        begin
            alu_a   = W'(rem_shift);
            alu_b   = W'(total_reg);
            alu_sub = 1'b1;
        end
        else if (mcand_reg[CHANNEL_BITS-1])
        begin
            alu_b = W'(t_reg);
        end
    end

    // timing checks
    logic          bad_cfg;
    logic [TW:0]   t_step;
    logic          is_last;

    assign bad_cfg = (fade_reg == '0) || (step_reg == '0)
                     || (TW'(step_reg) >= total_reg);
    assign t_step  = {1'b0, t_reg} + (TW + 1)'(step_reg);
    assign is_last = t_step > {1'b0, total_reg};

    logic load_out;

    always_comb
    begin
        state_next   = state_reg;
        elapsed_next = elapsed_reg;
        restart_next = restart_reg;
        total_next   = total_reg;
        t_next       = t_reg;
        err_next     = err_reg;
        last_next    = last_reg;
        ch_next      = ch_reg;
        cnt_next     = cnt_reg;
        mcand_next   = mcand_reg;
        acc_next     = acc_reg;
        res_next     = res_reg;
        load_out     = 1'b0;

        unique case (state_reg)
            lcfg_pkg::ST_IDLE:
            begin
                if (tick.valid)
                begin
                    restart_next = tick.restart;
                    state_next   = lcfg_pkg::ST_TOTAL;
                end
            end
            lcfg_pkg::ST_TOTAL:
            begin
                total_next = fade_reg * lcfg_pkg::NS_PER_SECOND;
                state_next = lcfg_pkg::ST_CHECK;
            end
            lcfg_pkg::ST_CHECK:
            begin
                err_next = bad_cfg;
                t_next   = (restart_reg || elapsed_reg > total_reg) ? '0 : elapsed_reg;
                if (bad_cfg)
                begin
                    last_next    = 1'b0;
                    elapsed_next = '0;
                    state_next   = lcfg_pkg::ST_DONE;
                end
                else
                begin
                    state_next = lcfg_pkg::ST_TIME;
                end
            end
            lcfg_pkg::ST_TIME:
            begin
                last_next    = is_last;
                elapsed_next = is_last ? '0 : t_step[TW-1:0];
                ch_next      = '0;
                state_next   = lcfg_pkg::ST_LOAD;
            end
            lcfg_pkg::ST_LOAD:
            begin
                mcand_next = cur_diff;
                acc_next   = '0;
                cnt_next   = CNT_W'(CHANNEL_BITS - 1);
                state_next = lcfg_pkg::ST_MUL;
            end
            lcfg_pkg::ST_MUL:
            begin
                acc_next   = alu_sum[W-1:0];
                mcand_next = mcand_reg << 1;
                if (cnt_reg == '0)
                begin
                    cnt_next   = CNT_W'(CHANNEL_BITS - 1);
                    state_next = lcfg_pkg::ST_DIV;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            lcfg_pkg::ST_DIV:
            begin
                acc_next = {rem_new, low_shift};
                if (cnt_reg == '0)
                begin
                    state_next = lcfg_pkg::ST_WRITE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            lcfg_pkg::ST_WRITE:
            begin
                res_next[ch_reg] = val_wide[OW-1:0];
                if (ch_reg == lcfg_pkg::LAST_CHAN)
                begin
                    state_next = lcfg_pkg::ST_DONE;
                end
                else
                begin
                    ch_next    = ch_reg + 1'b1;
                    state_next = lcfg_pkg::ST_LOAD;
                end
            end
            lcfg_pkg::ST_DONE:
            begin
                if (!out_valid_reg || color.ready)
                begin
                    load_out   = 1'b1;
                    state_next = lcfg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lcfg_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg && !color.ready;
        out_red_next    = out_red_reg;
        out_green_next  = out_green_reg;
        out_blue_next   = out_blue_reg;
        out_bright_next = out_bright_reg;
        out_last_next   = out_last_reg;
        out_err_next    = out_err_reg;
        if (load_out)
        begin
            out_valid_next  = 1'b1;
            out_red_next    = err_reg ? '0 : res_reg[0];
            out_green_next  = err_reg ? '0 : res_reg[1];
            out_blue_next   = err_reg ? '0 : res_reg[2];
            out_bright_next = err_reg ? '0 : res_reg[3];
            out_last_next   = last_reg;
            out_err_next    = err_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lcfg_pkg::ST_IDLE;
            start_reg     <= '0;
            end_reg       <= '0;
            fade_reg      <= lcfg_pkg::FADE_RESET;
            step_reg      <= lcfg_pkg::STEP_RESET;
            elapsed_reg   <= '0;
            out_valid_reg <= 1'b0;
            ch_reg        <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            elapsed_reg   <= elapsed_next;
            out_valid_reg <= out_valid_next;
            ch_reg        <= ch_next;
            cnt_reg       <= cnt_next;
            if (cfg.valid)
            begin
                unique case (cfg.addr)
                    lcfg_pkg::REG_START_COLOR:  start_reg <= cfg.data;
                    lcfg_pkg::REG_END_COLOR:    end_reg   <= cfg.data;
                    lcfg_pkg::REG_FADE_SECONDS: fade_reg  <= cfg.data[lcfg_pkg::FADE_W-1:0];
                    lcfg_pkg::REG_STEP_NS:      step_reg  <= cfg.data;
                    default:                    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        restart_reg    <= restart_next;
        total_reg      <= total_next;
        t_reg          <= t_next;
        err_reg        <= err_next;
        last_reg       <= last_next;
        mcand_reg      <= mcand_next;
        acc_reg        <= acc_next;
        res_reg        <= res_next;
        out_red_reg    <= out_red_next;
        out_green_reg  <= out_green_next;
        out_blue_reg   <= out_blue_next;
        out_bright_reg <= out_bright_next;
        out_last_reg   <= out_last_next;
        out_err_reg    <= out_err_next;
    end

    assign cfg.ready        = 1'b1;
    assign tick.ready       = (state_reg == lcfg_pkg::ST_IDLE);
    assign color.valid      = out_valid_reg;
    assign color.red        = out_red_reg;
    assign color.green      = out_green_reg;
    assign color.blue       = out_blue_reg;
    assign color.brightness = out_bright_reg;
    assign color.last       = out_last_reg;
    assign color.error      = out_err_reg;

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        tick.valid && tick.ready |=> state_reg == lcfg_pkg::ST_TOTAL)
        else $error("accepted item did not start the sequence");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lcfg_pkg::ST_DIV |-> acc_reg[W-1:CHANNEL_BITS] < total_reg)
        else $error("partial remainder not below fade length");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        color.valid && color.error |-> color.red == '0 && color.green == '0
            && color.blue == '0 && color.brightness == '0 && !color.last)
        else $error("error item carries nonzero fields");

    a_err_clears: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lcfg_pkg::ST_CHECK && bad_cfg |=> elapsed_reg == '0)
        else $error("elapsed time not cleared on invalid settings");

endmodule

// ===== dv/linear_color_fade_generator_tb.sv =====
// Testbench for linear_color_fade_generator: directed plan then random fades.
// Every color item is checked against a fade predictor kept in this file, or against a fixed color given in the plan.
// Depends on lcfg_pkg and the lcfg interfaces.
`timescale 1ns / 100ps

module linear_color_fade_generator_tb;

    localparam int          RAND_TICKS  = 1950;
    localparam int          CYCLE_LIMIT = 1000000;
    localparam int          DRAIN_WAIT  = 200;
    localparam int          MAX_NOTES   = 10;
    localparam logic [63:0] NS_PER_SEC  = 64'd1000000000;

    localparam logic [lcfg_pkg::CFG_ADDR_W-1:0] REG_UNMAPPED_A = 4'd9;
    localparam logic [lcfg_pkg::CFG_ADDR_W-1:0] REG_UNMAPPED_B = 4'd15;

    typedef struct packed {
        logic [lcfg_pkg::OUT_W-1:0] red;
        logic [lcfg_pkg::OUT_W-1:0] green;
        logic [lcfg_pkg::OUT_W-1:0] blue;
        logic [lcfg_pkg::OUT_W-1:0] brightness;
        logic                       last;
        logic                       error;
    } color_t;

    typedef struct packed {
        bit                              is_cfg;
        logic [lcfg_pkg::CFG_ADDR_W-1:0] idx;
        logic [lcfg_pkg::CFG_DATA_W-1:0] val;
        bit                              restart;
        bit                              typed;
        color_t                          want;
    } plan_row_t;

    localparam color_t BLACK_COLOR = '0;
    localparam color_t ERROR_COLOR = '{red: 8'd0, green: 8'd0, blue: 8'd0,
                                       brightness: 8'd0, last: 1'b0, error: 1'b1};

    logic clk;
    logic rst_n;

    lcfg_cfg_if   cfg_ch ();
    lcfg_tick_if  tick_ch ();
    lcfg_color_if color_ch ();

    linear_color_fade_generator u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .tick  (tick_ch),
        .color (color_ch)
    );

    // predictor state
    logic [lcfg_pkg::COLOR_W-1:0] start_col;
    logic [lcfg_pkg::COLOR_W-1:0] end_col;
    logic [lcfg_pkg::FADE_W-1:0]  fade_sec;
    logic [lcfg_pkg::STEP_W-1:0]  step_len;
    logic [lcfg_pkg::TIME_W-1:0]  elapsed;

    color_t    color_due_q[$];
    plan_row_t plan_q[$];

    int send_gap_pct;
    int recv_gap_pct;
    int cycles;
    int bad_items;
    int ticks_sent;
    int colors_seen;
    int lasts_seen;
    int errors_seen;
    int reg_writes;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic logic [63:0] fade_chan(input logic [63:0] s, input logic [63:0] e,
                                              input logic [63:0] t, input logic [63:0] tot);
        if (s == e)
            return s;
        if (s < e)
            return s + ((e - s) * t) / tot;
        return s - ((s - e) * t) / tot;
    endfunction

    function automatic color_t fade_next(input bit rs);
        logic [63:0]                tot;
        logic [63:0]                t;
        logic [63:0]                v;
        logic [63:0]                nxt;
        logic [lcfg_pkg::OUT_W-1:0] ch [lcfg_pkg::NUM_CHAN];
        color_t                     c;
        bit                         lst;
        tot = 64'(fade_sec) * NS_PER_SEC;
        if (fade_sec == '0 || step_len == '0 || 64'(step_len) >= tot)
        begin
            elapsed = '0;
            return ERROR_COLOR;
        end
        t = 64'(elapsed);
        if (rs || t > tot)
            t = '0;
        for (int i = 0; i < lcfg_pkg::NUM_CHAN; i++)
        begin
            v = fade_chan(64'((start_col >> ((3 - i) * 8)) & 32'hFF),
                          64'((end_col >> ((3 - i) * 8)) & 32'hFF), t, tot);
            ch[i] = v[lcfg_pkg::OUT_W-1:0];
        end
        nxt = t + 64'(step_len);
        lst = nxt > tot;
        elapsed = lst ? '0 : nxt[lcfg_pkg::TIME_W-1:0];
        c.red = ch[0];
        c.green = ch[1];
        c.blue = ch[2];
        c.brightness = ch[3];
        c.last = lst;
        c.error = 1'b0;
        return c;
    endfunction

    function automatic void plan_reg(input logic [lcfg_pkg::CFG_ADDR_W-1:0] idx,
                                     input logic [lcfg_pkg::CFG_DATA_W-1:0] val);
        plan_row_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.val = val;
        plan_q.push_back(r);
    endfunction

    function automatic void plan_tick(input bit rs, input bit typed, input color_t want);
        plan_row_t r;
        r = '0;
        r.restart = rs;
        r.typed = typed;
        r.want = want;
        plan_q.push_back(r);
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_tick(input bit rs, input bit typed, input color_t want);
        color_t pred;
        while ($urandom_range(99) < send_gap_pct)
        begin
            tick_ch.valid = 1'b0;
            @(negedge clk);
        end
        tick_ch.valid = 1'b1;
        tick_ch.restart = rs;
        @(posedge clk);
        while (!tick_ch.ready)
            @(posedge clk);
        pred = fade_next(rs);
        color_due_q.push_back(typed ? want : pred);
        ticks_sent++;
        @(negedge clk);
    endtask

    // only while idle: all colors back, then a short pause
    task automatic write_reg(input logic [lcfg_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [lcfg_pkg::CFG_DATA_W-1:0] val);
        tick_ch.valid = 1'b0;
        while (color_due_q.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.addr = idx;
        cfg_ch.data = val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            lcfg_pkg::REG_START_COLOR:  start_col = val;
            lcfg_pkg::REG_END_COLOR:    end_col = val;
            lcfg_pkg::REG_FADE_SECONDS: fade_sec = val[lcfg_pkg::FADE_W-1:0];
            lcfg_pkg::REG_STEP_NS:      step_len = val;
            default:                    ;
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    initial
    begin
        color_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            color_ch.ready = ($urandom_range(99) >= recv_gap_pct);
        end
    end

    always @(posedge clk)
    begin : check_color
        color_t got_c;
        color_t due_c;
        if (rst_n && color_ch.valid && color_ch.ready)
        begin
            got_c = {color_ch.red, color_ch.green, color_ch.blue, color_ch.brightness,
                     color_ch.last, color_ch.error};
            colors_seen++;
            if (got_c.last)
                lasts_seen++;
            if (got_c.error)
                errors_seen++;
            if (color_due_q.size() == 0)
            begin
                bad_items++;
                if (bad_items <= MAX_NOTES)
                    $display("unexpected color item at cycle %0d", cycles);
            end
            else
            begin
                due_c = color_due_q.pop_front();
                if (got_c.red != due_c.red || got_c.green != due_c.green ||
                    got_c.blue != due_c.blue || got_c.brightness != due_c.brightness ||
                    got_c.last != due_c.last || got_c.error != due_c.error)
                begin
                    bad_items++;
                    if (bad_items <= MAX_NOTES)
                    begin
                        $display("mismatch cycle %0d: exp r%0d g%0d b%0d br%0d l%0d e%0d",
                                 cycles, due_c.red, due_c.green, due_c.blue,
                                 due_c.brightness, due_c.last, due_c.error);
                        $display("    got r%0d g%0d b%0d br%0d l%0d e%0d",
                                 got_c.red, got_c.green, got_c.blue,
                                 got_c.brightness, got_c.last, got_c.error);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin : stimulus
        plan_row_t   r;
        int          phase_len;
        int          sent_rand;
        int          pick;
        logic [31:0] s_col;
        logic [31:0] e_col;
        logic [15:0] f_sec;
        logic [31:0] stp;
        logic [63:0] tot;
        logic [63:0] q;

        cycles = 0;
        bad_items = 0;
        ticks_sent = 0;
        colors_seen = 0;
        lasts_seen = 0;
        errors_seen = 0;
        reg_writes = 0;
        send_gap_pct = 12;
        recv_gap_pct = 50;
        start_col = '0;
        end_col = '0;
        fade_sec = lcfg_pkg::FADE_RESET;
        step_len = lcfg_pkg::STEP_RESET;
        elapsed = '0;
        rst_n = 1'b0;
        tick_ch.valid = 1'b0;
        tick_ch.restart = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.addr = '0;
        cfg_ch.data = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed plan
        plan_tick(1'b0, 1'b1, BLACK_COLOR);
        plan_tick(1'b1, 1'b1, BLACK_COLOR);
        plan_reg(lcfg_pkg::REG_START_COLOR, 32'h0000_0000);
        plan_reg(lcfg_pkg::REG_END_COLOR, 32'hFFFF_FFFF);
        plan_reg(lcfg_pkg::REG_FADE_SECONDS, 32'd1);
        plan_reg(lcfg_pkg::REG_STEP_NS, 32'd500000000);
        repeat (4) plan_tick(1'b0, 1'b0, BLACK_COLOR);
        // mixed rising and falling channels
        plan_reg(lcfg_pkg::REG_START_COLOR, 32'hFF00_FF80);
        plan_reg(lcfg_pkg::REG_END_COLOR, 32'h00FF_80FF);
        plan_reg(lcfg_pkg::REG_STEP_NS, 32'd300000000);
        plan_tick(1'b0, 1'b0, BLACK_COLOR);
        plan_tick(1'b0, 1'b0, BLACK_COLOR);
        plan_tick(1'b1, 1'b0, BLACK_COLOR);
        plan_tick(1'b0, 1'b0, BLACK_COLOR);
        // equal channels
        plan_reg(lcfg_pkg::REG_END_COLOR, 32'hFF00_FF80);
        plan_tick(1'b0, 1'b0, BLACK_COLOR);
        // invalid settings
        plan_reg(lcfg_pkg::REG_FADE_SECONDS, 32'd0);
        plan_tick(1'b0, 1'b1, ERROR_COLOR);
        plan_reg(lcfg_pkg::REG_FADE_SECONDS, 32'd1);
        plan_reg(lcfg_pkg::REG_STEP_NS, 32'd0);
        plan_tick(1'b0, 1'b1, ERROR_COLOR);
        plan_reg(lcfg_pkg::REG_STEP_NS, 32'd1000000000);
        plan_tick(1'b0, 1'b1, ERROR_COLOR);
        // longest valid step for a one second fade, then the largest step value
        plan_reg(lcfg_pkg::REG_END_COLOR, 32'h0180_7FFE);
        plan_reg(lcfg_pkg::REG_STEP_NS, 32'd999999999);
        plan_tick(1'b0, 1'b0, BLACK_COLOR);
        plan_tick(1'b0, 1'b0, BLACK_COLOR);
        plan_reg(lcfg_pkg::REG_FADE_SECONDS, 32'd4);
        plan_reg(lcfg_pkg::REG_STEP_NS, 32'hFFFF_FFFF);
        plan_tick(1'b0, 1'b1, ERROR_COLOR);
        plan_reg(lcfg_pkg::REG_FADE_SECONDS, 32'h0000_FFFF);
        plan_tick(1'b0, 1'b0, BLACK_COLOR);
        plan_tick(1'b0, 1'b0, BLACK_COLOR);
        // shrink the fade under the elapsed time
        plan_reg(lcfg_pkg::REG_FADE_SECONDS, 32'd3);
        plan_reg(lcfg_pkg::REG_STEP_NS, 32'd900000000);
        repeat (3) plan_tick(1'b0, 1'b0, BLACK_COLOR);
        plan_reg(lcfg_pkg::REG_FADE_SECONDS, 32'd1);
        plan_tick(1'b0, 1'b0, BLACK_COLOR);
        // unmapped indexes are ignored
        plan_reg(REG_UNMAPPED_A, 32'hDEAD_BEEF);
        plan_reg(REG_UNMAPPED_B, 32'hFFFF_FFFF);
        plan_tick(1'b0, 1'b0, BLACK_COLOR);

        while (plan_q.size() != 0)
        begin
            r = plan_q.pop_front();
            if (r.is_cfg)
                write_reg(r.idx, r.val);
            else
                send_tick(r.restart, r.typed, r.want);
        end

        // random fades
        sent_rand = 0;
        while (sent_rand < RAND_TICKS)
        begin
            pick = $urandom_range(99);
            if (pick < 12)
            begin
                write_reg(lcfg_pkg::REG_FADE_SECONDS, 32'($urandom_range(1, 2)));
            end
            else
            begin
                s_col = $urandom;
                e_col = $urandom;
                if ($urandom_range(5) == 0)
                    e_col = s_col ^ ($urandom & 32'hFF00_FF00);
                pick = $urandom_range(99);
                if (pick < 70)
                    f_sec = 16'($urandom_range(1, 3));
                else if (pick < 80)
                    f_sec = 16'($urandom);
                else if (pick < 90)
                    f_sec = 16'd0;
                else
                    f_sec = 16'hFFFF;
                tot = 64'(f_sec) * NS_PER_SEC;
                pick = $urandom_range(99);
                if (pick < 5)
                    stp = 32'd0;
                else if (pick < 12 || tot == 0)
                    stp = $urandom;
                else
                begin
                    q = tot / 64'($urandom_range(1, 40));
                    if (q > 64'hFFFF_FFFF)
                        q = 64'hFFFF_FFFF;
                    if (q > 64'd3)
                        q = q - 64'($urandom_range(0, 3));
                    stp = q[31:0];
                end
                write_reg(lcfg_pkg::REG_START_COLOR, s_col);
                write_reg(lcfg_pkg::REG_END_COLOR, e_col);
                write_reg(lcfg_pkg::REG_FADE_SECONDS, 32'(f_sec));
                write_reg(lcfg_pkg::REG_STEP_NS, stp);
                if ($urandom_range(7) == 0)
                    write_reg(4'($urandom_range(4, 15)), $urandom);
            end
            phase_len = $urandom_range(60, 200);
            while (phase_len > 0 && sent_rand < RAND_TICKS)
            begin
                if (sent_rand < RAND_TICKS / 3)
                begin
                    send_gap_pct = 12;
                    recv_gap_pct = 50;
                end
                else if (sent_rand < 2 * RAND_TICKS / 3)
                begin
                    send_gap_pct = 50;
                    recv_gap_pct = 12;
                end
                else
                begin
                    send_gap_pct = 0;
                    recv_gap_pct = 0;
                end
                send_tick($urandom_range(99) < 4, 1'b0, BLACK_COLOR);
                sent_rand++;
                phase_len--;
            end
        end
        tick_ch.valid = 1'b0;

        while (color_due_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("ran %0d ticks over %0d register writes in %0d cycles",
                 ticks_sent, reg_writes, cycles);
        $display("checked %0d colors: %0d fade ends, %0d invalid settings, %0d bad",
                 colors_seen, lasts_seen, errors_seen, bad_items);
        if (bad_items == 0 && color_due_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/lcfg_pkg.sv
rtl/core/lcfg_if.sv
rtl/core/linear_color_fade_generator.sv
dv/linear_color_fade_generator_tb.sv
